// ===== hdl/acm_pkg.sv =====
// Package: constants and item types for the accelerometer offset/magnitude block.
package acm_pkg;

  localparam int CALIB_SAMPLES = 500;
  localparam int ONE_G         = 16384;
  localparam int AXES          = 3;
  localparam int DATA_W        = 16;

  // calibration count and per-axis sum
  localparam int CNT_W  = $clog2(CALIB_SAMPLES + 1);
  localparam int SUM_W  = CNT_W + DATA_W;
  // magnitude of a sum; serial divider remainder
  localparam int DVD_W  = SUM_W - 1;
  localparam int REM_W  = $clog2(CALIB_SAMPLES) + 1;

  // squares and root
  localparam int SQ_W   = 2 * DATA_W;
  localparam int RAD_W  = SQ_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int SRM_W  = ROOT_W + 2;

  localparam int MAX_STEPS = (DVD_W > ROOT_W) ? DVD_W : ROOT_W;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] accel_x;
    logic signed [DATA_W-1:0] accel_y;
    logic signed [DATA_W-1:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] corrected_x;
    logic signed [DATA_W-1:0] corrected_y;
    logic signed [DATA_W-1:0] corrected_z;
    logic        [DATA_W-1:0] magnitude;
  } result_t;

endpackage

// ===== hdl/accel_offset_calibrate_magnitude.sv =====
// Top level: offset calibration, offset removal and bit-serial magnitude.
//
//   channel  | signals                               | dir | payload
//   ---------+---------------------------------------+-----+----------------------
//   sample   | sample_valid, sample_ready, sample    | in  | acm_pkg::sample_t
//   result   | result_valid, result_ready, result    | out | acm_pkg::result_t
//
// A calibration item only adds into the sums; the last one also starts the
// bit-serial divide of the sums by the sample count. A measured item runs from
// accept through the three shift-add squarers, the sum of squares, the
// bit-a-cycle square root and the output load; only idle takes a new sample.
// Synchronous reset clears the count, sums, offsets and the output valid.
// A result waiting in the output register does not stop the next item; only a
// second finished result waits for the register to drain.
module accel_offset_calibrate_magnitude (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  acm_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_ready,
  output acm_pkg::result_t result
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_ROOT = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]                        state;
  logic [acm_pkg::CNT_W-1:0]         calib_count;
  logic signed [acm_pkg::SUM_W-1:0]  axis_sum    [acm_pkg::AXES];
  logic signed [acm_pkg::DATA_W-1:0] axis_offset [acm_pkg::AXES];
  logic [acm_pkg::STEP_W-1:0]        step;

  // divider lanes
  logic [acm_pkg::DVD_W-1:0] dvd  [acm_pkg::AXES];
  logic [acm_pkg::REM_W-1:0] drem [acm_pkg::AXES];
  logic                      dneg [acm_pkg::AXES];

  // squarer lanes
  logic [acm_pkg::DATA_W-1:0] corr  [acm_pkg::AXES];
  logic [acm_pkg::DATA_W-1:0] mcand [acm_pkg::AXES];
  logic [acm_pkg::DATA_W-1:0] mhi   [acm_pkg::AXES];
  logic [acm_pkg::DATA_W-1:0] mlo   [acm_pkg::AXES];

  // square root
  logic [acm_pkg::RAD_W-1:0]  rad;
  logic [acm_pkg::SRM_W-1:0]  srem;
  logic [acm_pkg::ROOT_W-1:0] root;

  // combinational
  logic signed [acm_pkg::DATA_W-1:0] raw       [acm_pkg::AXES];
  logic signed [acm_pkg::SUM_W-1:0]  sum_next  [acm_pkg::AXES];
  logic [acm_pkg::DVD_W-1:0]         sum_abs   [acm_pkg::AXES];
  logic [acm_pkg::REM_W:0]           dtrial    [acm_pkg::AXES];
  logic                              dge       [acm_pkg::AXES];
  logic [acm_pkg::REM_W-1:0]         drem_next [acm_pkg::AXES];
  logic [acm_pkg::DATA_W-1:0]        quot      [acm_pkg::AXES];
  logic [acm_pkg::DATA_W-1:0]        off_next  [acm_pkg::AXES];
  logic [acm_pkg::DATA_W-1:0]        corr_next [acm_pkg::AXES];
  logic [acm_pkg::DATA_W-1:0]        abs_next  [acm_pkg::AXES];
  logic [acm_pkg::DATA_W:0]          msum      [acm_pkg::AXES];
  logic [acm_pkg::RAD_W-1:0]         sq_sum;
  logic [acm_pkg::SRM_W+1:0]         strial;
  logic [acm_pkg::SRM_W+1:0]         sdiv;
  logic                              sge;
  logic [acm_pkg::SRM_W-1:0]         srem_next;

  logic accept;
  logic calib_done;
  logic calib_last;
  logic out_free;

  assign sample_ready = (state == ST_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign calib_done   = (calib_count == acm_pkg::CNT_W'(acm_pkg::CALIB_SAMPLES));
  assign calib_last   = (calib_count == acm_pkg::CNT_W'(acm_pkg::CALIB_SAMPLES - 1));
  assign out_free     = !result_valid || result_ready;

  assign raw[0] = sample.accel_x;
  assign raw[1] = sample.accel_y;
  assign raw[2] = sample.accel_z;

  always_comb begin
    for (int i = 0; i < acm_pkg::AXES; i++) begin
      sum_next[i] = axis_sum[i] + acm_pkg::SUM_W'(raw[i]);
      sum_abs[i]  = sum_next[i][acm_pkg::SUM_W-1] ? acm_pkg::DVD_W'(-sum_next[i])
                                                  : acm_pkg::DVD_W'(sum_next[i]);
      // restoring divide by the sample count, one quotient bit a cycle
      dtrial[i]    = {drem[i], dvd[i][acm_pkg::DVD_W-1]};
      dge[i]       = (dtrial[i] >= (acm_pkg::REM_W+1)'(acm_pkg::CALIB_SAMPLES));
      drem_next[i] = dge[i]
                     ? acm_pkg::REM_W'(dtrial[i] - (acm_pkg::REM_W+1)'(acm_pkg::CALIB_SAMPLES))
                     : acm_pkg::REM_W'(dtrial[i]);
      quot[i]      = acm_pkg::DATA_W'({dvd[i][acm_pkg::DVD_W-2:0], dge[i]});
      off_next[i]  = dneg[i] ? -quot[i] : quot[i];
      corr_next[i] = raw[i] - axis_offset[i];
      abs_next[i]  = corr_next[i][acm_pkg::DATA_W-1] ? -corr_next[i] : corr_next[i];
      msum[i]      = {1'b0, mhi[i]} + (mlo[i][0] ? {1'b0, mcand[i]} : '0);
    end
    // Z offset also carries one g
    off_next[2] = off_next[2] - acm_pkg::DATA_W'(acm_pkg::ONE_G);
  end

  assign sq_sum = acm_pkg::RAD_W'({mhi[0], mlo[0]}) + acm_pkg::RAD_W'({mhi[1], mlo[1]})
                + acm_pkg::RAD_W'({mhi[2], mlo[2]});

  // square root: two radicand bits enter the remainder each cycle
  assign strial    = {srem, rad[acm_pkg::RAD_W-1 -: 2]};
  assign sdiv      = (acm_pkg::SRM_W+2)'({root, 2'b01});
  assign sge       = (strial >= sdiv);
  assign srem_next = sge ? acm_pkg::SRM_W'(strial - sdiv) : acm_pkg::SRM_W'(strial);

  // control and calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      calib_count  <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < acm_pkg::AXES; i++) begin
        axis_sum[i]    <= '0;
        axis_offset[i] <= '0;
      end
    end else begin
      // in ST_FIN the load below decides the valid
      if (result_valid && result_ready && (state != ST_FIN)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!calib_done) begin
              calib_count <= calib_count + 1'b1;
              for (int i = 0; i < acm_pkg::AXES; i++) begin
                axis_sum[i] <= sum_next[i];
              end
              if (calib_last) begin
                state <= ST_DIV;
              end
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_DIV: begin
          if (step == acm_pkg::STEP_W'(acm_pkg::DVD_W - 1)) begin
            for (int i = 0; i < acm_pkg::AXES; i++) begin
              axis_offset[i] <= off_next[i];
            end
            state <= ST_IDLE;
          end
        end
        ST_MUL: begin
          if (step == acm_pkg::STEP_W'(acm_pkg::DATA_W - 1)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (step == acm_pkg::STEP_W'(acm_pkg::ROOT_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        step <= '0;
        for (int i = 0; i < acm_pkg::AXES; i++) begin
          dvd[i]   <= sum_abs[i];
          dneg[i]  <= sum_next[i][acm_pkg::SUM_W-1];
          drem[i]  <= '0;
          corr[i]  <= corr_next[i];
          mcand[i] <= abs_next[i];
          mhi[i]   <= '0;
          mlo[i]   <= abs_next[i];
        end
      end
      ST_DIV: begin
        step <= step + 1'b1;
        for (int i = 0; i < acm_pkg::AXES; i++) begin
          drem[i] <= drem_next[i];
          dvd[i]  <= {dvd[i][acm_pkg::DVD_W-2:0], dge[i]};
        end
      end
      ST_MUL: begin
        step <= step + 1'b1;
        for (int i = 0; i < acm_pkg::AXES; i++) begin
          mhi[i] <= msum[i][acm_pkg::DATA_W:1];
          mlo[i] <= {msum[i][0], mlo[i][acm_pkg::DATA_W-1:1]};
        end
      end
      ST_ADD: begin
        step <= '0;
        rad  <= sq_sum;
        srem <= '0;
        root <= '0;
      end
      ST_ROOT: begin
        step <= step + 1'b1;
        rad  <= {rad[acm_pkg::RAD_W-3:0], 2'b00};
        srem <= srem_next;
        root <= {root[acm_pkg::ROOT_W-2:0], sge};
      end
      ST_FIN: begin
        if (out_free) begin
          result.corrected_x <= corr[0];
          result.corrected_y <= corr[1];
          result.corrected_z <= corr[2];
          result.magnitude   <= root[acm_pkg::DATA_W-1:0];
        end
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

// ===== hdl/acm_checker.sv =====
// Checker: port-level properties of the offset/magnitude block, bound to the top.
module acm_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_ready,
  input logic             result_valid,
  input logic             result_ready,
  input acm_pkg::result_t result
);

  logic [acm_pkg::DATA_W-1:0] ax, ay, az;
  logic [acm_pkg::RAD_W-1:0]  sumsq;
  logic [acm_pkg::RAD_W-1:0]  msq;
  logic [acm_pkg::RAD_W-1:0]  m1sq;

  assign ax = result.corrected_x[acm_pkg::DATA_W-1] ? -result.corrected_x : result.corrected_x;
  assign ay = result.corrected_y[acm_pkg::DATA_W-1] ? -result.corrected_y : result.corrected_y;
  assign az = result.corrected_z[acm_pkg::DATA_W-1] ? -result.corrected_z : result.corrected_z;
  assign sumsq = acm_pkg::RAD_W'(ax) * acm_pkg::RAD_W'(ax)
               + acm_pkg::RAD_W'(ay) * acm_pkg::RAD_W'(ay)
               + acm_pkg::RAD_W'(az) * acm_pkg::RAD_W'(az);
  assign msq  = acm_pkg::RAD_W'(result.magnitude) * acm_pkg::RAD_W'(result.magnitude);
  assign m1sq = (acm_pkg::RAD_W'(result.magnitude) + 1'b1)
              * (acm_pkg::RAD_W'(result.magnitude) + 1'b1);

  // a waiting item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // magnitude is the floor root of the corrected axes
  a_root: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (msq <= sumsq) && (sumsq < m1sq))
    else $error("magnitude is not floor sqrt of corrected axes");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.magnitude <= 16'd56755)
    else $error("magnitude out of range");

  // a new result only appears after a busy stretch
  a_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!sample_ready))
    else $error("result appeared without a computation");

endmodule

bind accel_offset_calibrate_magnitude acm_checker u_acm_checker (.*);

// ===== test/acm_result_checker.sv =====
`timescale 1ns / 100ps
// Checker: tracks calibration, predicts corrected axes and magnitude, compares results.
module acm_result_checker (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       sample_valid,
  input  logic                                       sample_ready,
  input  acm_pkg::sample_t                           sample,
  input  logic                                       result_valid,
  input  logic                                       result_ready,
  input  acm_pkg::result_t                           result,
  output int                                         mismatch_count,
  output int                                         outstanding,
  output int                                         items_seen,
  output logic [acm_pkg::AXES-1:0][acm_pkg::DATA_W-1:0] axis_offset
);
  import acm_pkg::*;

  result_t expected_results [$];
  int      cal_taken;
  int      axis_sum [AXES];

  // bit-by-bit floor square root; the root of a 34-bit sum needs 17 bits
  function automatic logic [DATA_W-1:0] floor_sqrt34(input longint unsigned radicand);
    logic [DATA_W:0]  root;
    longint unsigned  trial;
    root = '0;
    for (int b = DATA_W; b >= 0; b--) begin
      trial = root | ((DATA_W + 1)'(1) << b);
      if (trial * trial <= radicand) root = root | ((DATA_W + 1)'(1) << b);
    end
    return root[DATA_W-1:0];
  endfunction

  function automatic result_t offset_result(input sample_t s);
    result_t                     r;
    logic [AXES-1:0][DATA_W-1:0] raw;
    logic [AXES-1:0][DATA_W-1:0] cor;
    logic signed [DATA_W-1:0]    c;
    longint unsigned             sumsq;
    raw   = {s.accel_z, s.accel_y, s.accel_x};
    sumsq = 0;
    for (int i = 0; i < AXES; i++) begin
      c      = raw[i] - axis_offset[i];
      cor[i] = c;
      sumsq += longint'(c) * longint'(c);
    end
    r.corrected_x = cor[0];
    r.corrected_y = cor[1];
    r.corrected_z = cor[2];
    r.magnitude   = floor_sqrt34(sumsq);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    items_seen     = 0;
  end

  always @(posedge clk) begin : monitor
    result_t want;
    int      q;
    if (rst) begin
      expected_results.delete();
      cal_taken   = 0;
      axis_sum    = '{default: 0};
      axis_offset = '0;
      outstanding = 0;
      items_seen  = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: %p", result);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("corrected_x", want.corrected_x, result.corrected_x);
          check_field("corrected_y", want.corrected_y, result.corrected_y);
          check_field("corrected_z", want.corrected_z, result.corrected_z);
          check_field("magnitude", want.magnitude, result.magnitude);
        end
      end
      if (sample_valid && sample_ready) begin
        if (cal_taken < CALIB_SAMPLES) begin
          axis_sum[0] += sample.accel_x;
          axis_sum[1] += sample.accel_y;
          axis_sum[2] += sample.accel_z;
          cal_taken++;
          // offsets truncate toward zero; Z also drops one g and may wrap
          if (cal_taken == CALIB_SAMPLES) begin
            for (int i = 0; i < AXES; i++) begin
              q = axis_sum[i] / CALIB_SAMPLES;
              if (i == 2) q -= ONE_G;
              axis_offset[i] = q[DATA_W-1:0];
            end
          end
        end else begin
          expected_results.push_back(offset_result(sample));
        end
      end
      outstanding = expected_results.size();
      // counted last so a waiter never sees the item before its expectation
      if (sample_valid && sample_ready) items_seen++;
    end
  end

endmodule

// ===== test/tb_accel_offset_calibrate_magnitude.sv =====
`timescale 1ns / 100ps
// Testbench top: sample stimulus, result back-pressure and the final verdict.
module tb_accel_offset_calibrate_magnitude;
  import acm_pkg::*;

  logic    clk;
  logic    rst;
  logic    sample_valid;
  logic    sample_ready;
  sample_t sample;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  int                          mismatch_count;
  int                          outstanding;
  int                          items_seen;
  int                          items_sent;
  logic [AXES-1:0][DATA_W-1:0] axis_offset;
  bit                          steady;
  bit                          long_hold;

  accel_offset_calibrate_magnitude u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  acm_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample         (sample),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .items_seen     (items_seen),
    .axis_offset    (axis_offset)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rnd16();
    return DATA_W'($urandom);
  endfunction

  // raw sample that lands on the given corrected values
  function automatic sample_t from_corrected(input int cx, input int cy, input int cz);
    sample_t s;
    s.accel_x = axis_offset[0] + cx[DATA_W-1:0];
    s.accel_y = axis_offset[1] + cy[DATA_W-1:0];
    s.accel_z = axis_offset[2] + cz[DATA_W-1:0];
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    items_sent++;
  endtask

  initial begin
    sample_t s;
    int      k;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    items_sent   = 0;
    steady       = 1'b0;
    long_hold    = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // calibration: extremes, then Z well below -1 g so the Z offset wraps
    send_sample('{16'h8000, 16'h8000, 16'h8000});
    send_sample('{16'h7fff, 16'h7fff, 16'h7fff});
    send_sample('0);
    for (int i = 3; i < CALIB_SAMPLES; i++) begin
      steady    = (i >= 150 && i < 260);
      s.accel_x = rnd16();
      s.accel_y = DATA_W'($urandom_range(0, 4000)) - 16'd3000;
      s.accel_z = DATA_W'($urandom_range(0, 12768)) - 16'h8000;
      send_sample(s);
    end
    steady = 1'b0;

    // measured items: raw extremes first, then aimed at corrected extremes
    send_sample('{16'h8000, 16'h8000, 16'h8000});
    send_sample('{16'h7fff, 16'h7fff, 16'h7fff});
    send_sample('0);
    send_sample(from_corrected(0, 0, 0));
    send_sample(from_corrected(-32768, -32768, -32768));
    send_sample(from_corrected(32767, 32767, 32767));
    send_sample(from_corrected(-32768, 32767, -32768));
    send_sample(from_corrected(1, 0, 0));
    send_sample(from_corrected(0, 0, ONE_G));
    send_sample(from_corrected(-1, -1, -1));
    send_sample(from_corrected(0, -32768, 0));

    long_hold = 1'b1;
    for (int i = 0; i < 160; i++) begin
      steady = (i >= 60 && i < 90);
      k      = $urandom_range(0, 9);
      if (k < 4) begin
        s = {rnd16(), rnd16(), rnd16()};
      end else if (k < 8) begin
        // near rest: small noise around one g on Z
        s = from_corrected(int'($urandom_range(0, 4000)) - 2000,
                           int'($urandom_range(0, 4000)) - 2000,
                           ONE_G + int'($urandom_range(0, 4000)) - 2000);
      end else begin
        s = from_corrected(int'($urandom), int'($urandom), int'($urandom));
      end
      send_sample(s);
    end
    sample_valid <= 1'b0;

    wait (items_seen == items_sent && outstanding == 0);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // result back-pressure, with one long hold-off to back up the block
  initial begin
    int hold;
    result_ready <= 1'b0;
    wait (!rst);
    forever begin
      if (long_hold) begin
        result_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (steady) begin
        result_ready <= 1'b1;
        @(posedge clk);
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          result_ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
